[src/rpr_pkg.sv]
// shared types, constants and helpers for the random page replacement unit
package rpr_pkg;

    localparam int FRAMES_DEF = 8;
    localparam int FRAMES_MAX = 64;
    localparam int FIDX_W     = $clog2(FRAMES_MAX);
    localparam int PAGE_W     = 16;
    localparam int VICT_W     = 3;
    localparam int HIT_W      = 32;

    // input transaction payload
    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic [VICT_W-1:0] victim_frame;
    } t_ref;

    // output transaction payload
    typedef struct packed {
        logic              was_hit;
        logic              was_replaced;
        logic [VICT_W-1:0] frame_index;
        logic [PAGE_W-1:0] evicted_page;
        logic [HIT_W-1:0]  hit_total;
    } t_res;

    // search token walking down the frame chain
    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
        logic [FIDX_W-1:0] victim;
        logic              hit;
        logic [FIDX_W-1:0] hit_idx;
        logic              empty;
        logic [FIDX_W-1:0] empty_idx;
        logic [PAGE_W-1:0] victim_page;
    } t_token;

    // frame write broadcast to every cell
    typedef struct packed {
        logic              en;
        logic [FIDX_W-1:0] idx;
        logic [PAGE_W-1:0] page;
    } t_wr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // victim index wrapped into the frame count, repeated subtraction on 6 bits
    function automatic logic [FIDX_W-1:0] frame_mod(input logic [VICT_W-1:0] v, input int n);
        logic [FIDX_W-1:0] r;
        r = FIDX_W'(v);
        for (int k = 0; k < 8; k++) begin
            if (int'(r) >= n) begin
                r = r - FIDX_W'(n);
            end
        end
        return r;
    endfunction

endpackage

[src/rpr_if.sv]
// handshake interfaces for page references and replacement results
interface rpr_ref_if;
    import rpr_pkg::*;
    logic valid;
    logic ready;
    t_ref data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rpr_res_if;
    import rpr_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/rpr_cell.sv]
// one frame cell: holds a page and updates the passing search token
module rpr_cell
    import rpr_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_token i_tok,
    input  t_wr    i_wr,
    output t_token o_tok
);

    localparam logic [FIDX_W-1:0] MY_IDX = FIDX_W'(CELL_IDX);

    logic [PAGE_W-1:0] r_page;
    t_token            r_tok;
    t_token            n_tok;

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && r_page == i_tok.page) begin
            n_tok.hit     = 1'b1;
            n_tok.hit_idx = MY_IDX;
        end
        if (!i_tok.empty && r_page == '0) begin
            n_tok.empty     = 1'b1;
            n_tok.empty_idx = MY_IDX;
        end
        if (i_tok.victim == MY_IDX) begin
            n_tok.victim_page = r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page      <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            if (i_wr.en && i_wr.idx == MY_IDX) begin
                r_page <= i_wr.page;
            end
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

[src/random_page_replacement_unit.sv]
// random page replacement unit: frame cell chain with search control and result register
// a new reference is taken only after the previous one's token has walked the cell chain and its result is committed
// a zero page reference is accepted and dropped with no result
// reset (synchronous, active low) empties every frame and clears the hit counter
// a finished result waits in the output register while the next reference is taken
module random_page_replacement_unit
    import rpr_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    rpr_ref_if.sink    i_ref,
    rpr_res_if.source  o_res
);

    t_state r_state;
    t_state n_state;

    // captured reference
    logic [PAGE_W-1:0] r_page;
    logic [VICT_W-1:0] r_victim;
    logic              r_start;

    // token chain, entry zero driven here, last entry comes back
    t_token tok [FRAMES+1];
    t_token r_acc;

    logic             r_out_valid;
    t_res             r_out;
    logic [HIT_W-1:0] r_hit_count;
    logic [HIT_W-1:0] n_hit_count;

    logic              in_fire;
    logic              out_free;
    logic              commit;
    logic              ref_ready;
    logic [FIDX_W-1:0] frame_sel;
    t_wr               wr;

    assign in_fire  = i_ref.valid && ref_ready;
    assign out_free = !r_out_valid || o_res.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && i_ref.data.page_number != '0) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tok[FRAMES].valid) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        ref_ready = 1'b0;
        commit    = 1'b0;
        unique case (r_state)
            ST_IDLE: ref_ready = 1'b1;
            ST_SCAN: ;
            ST_DONE: commit = out_free;
            default: ;
        endcase
    end

    // token launched into the first cell the cycle after accept
    always_comb begin
        tok[0]             = '0;
        tok[0].valid       = r_start;
        tok[0].page        = r_page;
        tok[0].victim      = frame_mod(r_victim, FRAMES);
    end

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        rpr_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (tok[g]),
            .i_wr   (wr),
            .o_tok  (tok[g+1])
        );
    end

    // frame chosen: hit first, then lowest empty, then wrapped victim
    always_comb begin
        if (r_acc.hit) begin
            frame_sel = r_acc.hit_idx;
        end else if (r_acc.empty) begin
            frame_sel = r_acc.empty_idx;
        end else begin
            frame_sel = r_acc.victim;
        end
        wr.en   = commit && !r_acc.hit;
        wr.idx  = frame_sel;
        wr.page = r_acc.page;
    end

    // saturating hit counter
    always_comb begin
        n_hit_count = r_hit_count;
        if (commit && r_acc.hit && r_hit_count != '1) begin
            n_hit_count = r_hit_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_hit_count <= '0;
        end else begin
            r_state     <= n_state;
            r_start     <= in_fire && i_ref.data.page_number != '0;
            r_hit_count <= n_hit_count;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_page   <= i_ref.data.page_number;
            r_victim <= i_ref.data.victim_frame;
        end
        if (r_state == ST_SCAN && tok[FRAMES].valid) begin
            r_acc <= tok[FRAMES];
        end
        if (commit) begin
            r_out.was_hit      <= r_acc.hit;
            r_out.was_replaced <= !r_acc.hit && !r_acc.empty;
            r_out.frame_index  <= frame_sel[VICT_W-1:0];
            r_out.evicted_page <= (!r_acc.hit && !r_acc.empty) ? r_acc.victim_page : '0;
            r_out.hit_total    <= n_hit_count;
        end
    end

    assign i_ref.ready = ref_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

[src/rpr_checker.sv]
// port-level checks for the random page replacement unit, bound to the top level
module rpr_checker
    import rpr_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_res i_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.was_hit |->
            !i_out_data.was_replaced && i_out_data.evicted_page == '0)
        else $error("hit reported an eviction");

    // only resident pages are evicted, and only on replacement
    a_evict_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.was_replaced == (i_out_data.evicted_page != '0)))
        else $error("evicted page does not match replace flag");

    // a hit result always carries a nonzero total
    a_hit_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.was_hit |-> i_out_data.hit_total != '0)
        else $error("hit with zero hit total");

endmodule

bind random_page_replacement_unit rpr_checker u_rpr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_out_data (o_res.data)
);

[tb/tb_random_page_replacement_unit.sv]
// self-checking testbench for the random page replacement unit
module tb_random_page_replacement_unit;
    import rpr_pkg::*;

    localparam int FRAMES       = FRAMES_DEF;
    localparam int RANDOM_REFS  = 1450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = FRAMES + 8;
    localparam int HOLD_CYCLES  = 160;
    localparam int PRINT_CAP    = 100;

    // one queued page reference with its lead-in gap and an optional wait for an empty pipe
    typedef struct {
        t_ref req;
        int   gap;
        bit   drain;
    } t_page_ref;

    logic i_clk;
    logic i_rst_n;

    rpr_ref_if req_if ();
    rpr_res_if res_if ();

    random_page_replacement_unit #(
        .FRAMES (FRAMES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ref   (req_if),
        .o_res   (res_if)
    );

    // shadow of the frame table and the hit counter
    logic [PAGE_W-1:0] frame_table [FRAMES];
    logic [HIT_W-1:0]  hits_seen;

    t_page_ref pending_refs [$];
    t_res      expected_outcomes [$];

    int mismatches;
    int cycles;

    // driver state
    t_page_ref cur;
    bit        loaded;
    int        gap_left;
    int        outstanding;
    bit        offer;

    // receiver state
    int stall_left;
    bit sink_calm;
    int refs_seen;
    int hold_cycles;

    // clock and reset
    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        res_if.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always #2 i_clk = ~i_clk;

    // predicts the outcome of one nonzero reference and updates the shadow table
    function automatic t_res resolve_reference(input t_ref r);
        t_res o;
        int   hit_at;
        int   empty_at;
        int   slot;
        o        = '0;
        hit_at   = -1;
        empty_at = -1;
        for (int i = 0; i < FRAMES; i++) begin
            if (hit_at < 0 && frame_table[i] == r.page_number) begin
                hit_at = i;
            end
            if (empty_at < 0 && frame_table[i] == '0) begin
                empty_at = i;
            end
        end
        if (hit_at >= 0) begin
            // resident page, counter sticks at its top value
            o.was_hit = 1'b1;
            slot      = hit_at;
            if (hits_seen != '1) begin
                hits_seen = hits_seen + 1'b1;
            end
        end else if (empty_at >= 0) begin
            // lowest empty frame takes the page
            slot              = empty_at;
            frame_table[slot] = r.page_number;
        end else begin
            // table full, victim index wraps into the frame count
            slot              = int'(r.victim_frame) % FRAMES;
            o.was_replaced    = 1'b1;
            o.evicted_page    = frame_table[slot];
            frame_table[slot] = r.page_number;
        end
        o.frame_index = VICT_W'(slot);
        o.hit_total   = hits_seen;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        // keep the log bounded when the block is badly broken
        if (mismatches < PRINT_CAP) begin
            $display("[%0d] mismatch on %s: got %0h expected %0h", cycles, what, got, want);
        end
        mismatches++;
    endtask

    task automatic check_outcome(input t_res got, input t_res want);
        if (got.was_hit !== want.was_hit) begin
            report_mismatch("was_hit", 32'(got.was_hit), 32'(want.was_hit));
        end
        if (got.was_replaced !== want.was_replaced) begin
            report_mismatch("was_replaced", 32'(got.was_replaced), 32'(want.was_replaced));
        end
        if (got.frame_index !== want.frame_index) begin
            report_mismatch("frame_index", 32'(got.frame_index), 32'(want.frame_index));
        end
        if (got.evicted_page !== want.evicted_page) begin
            report_mismatch("evicted_page", 32'(got.evicted_page), 32'(want.evicted_page));
        end
        if (got.hit_total !== want.hit_total) begin
            report_mismatch("hit_total", got.hit_total, want.hit_total);
        end
    endtask

    task automatic queue_ref(input logic [PAGE_W-1:0] page, input logic [VICT_W-1:0] victim,
                             input int gap, input bit drain);
        t_page_ref p;
        p.req.page_number  = page;
        p.req.victim_frame = victim;
        p.gap              = gap;
        p.drain            = drain;
        pending_refs.insert(pending_refs.size(), p);
    endtask

    // driver: takes the next queued reference, waits out its gap, then offers it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
            loaded      = 1'b0;
            gap_left    = 0;
            outstanding = 0;
            for (int i = 0; i < FRAMES; i++) begin
                frame_table[i] = '0;
            end
            hits_seen = '0;
        end else begin
            // results still owed by the block, tracked from the handshakes themselves
            if (res_if.valid && res_if.ready) begin
                outstanding--;
            end
            if (req_if.valid && req_if.ready) begin
                // zero page is swallowed with no result
                if (cur.req.page_number != '0) begin
                    expected_outcomes.insert(expected_outcomes.size(),
                                             resolve_reference(cur.req));
                    outstanding++;
                end
                loaded = 1'b0;
            end
            if (!loaded && pending_refs.size() != 0) begin
                cur = pending_refs[0];
                pending_refs.delete(0);
                loaded   = 1'b1;
                gap_left = cur.gap;
            end
            offer = 1'b0;
            if (loaded) begin
                if (cur.drain && outstanding != 0) begin
                    offer = 1'b0;
                end else if (gap_left != 0) begin
                    cur.drain = 1'b0;
                    gap_left--;
                end else begin
                    cur.drain = 1'b0;
                    offer     = 1'b1;
                end
            end
            // a single assignment per edge keeps valid steady across back-to-back items
            req_if.valid <= offer;
            if (offer) begin
                req_if.data <= cur.req;
            end
        end
    end

    // long receiver hold-off, started twice once enough references have gone in
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            refs_seen   <= 0;
            hold_cycles <= 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                refs_seen <= refs_seen + 1;
            end
            if (hold_cycles != 0) begin
                hold_cycles <= hold_cycles - 1;
            end else if (req_if.valid && req_if.ready &&
                         (refs_seen == 300 || refs_seen == 1000)) begin
                hold_cycles <= HOLD_CYCLES;
            end
        end
    end

    // monitor: checks each result transaction and draws the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
            sink_calm  = 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unexpected result", res_if.data.hit_total, '0);
                end else begin
                    check_outcome(res_if.data, expected_outcomes[0]);
                    expected_outcomes.delete(0);
                end
                stall_left = sink_calm ? 0 : $urandom_range(0, 9);
                // switch between stalling and stall-free stretches now and then
                if ($urandom_range(0, 59) == 0) begin
                    sink_calm = !sink_calm;
                end
            end else if (stall_left != 0 && hold_cycles == 0) begin
                stall_left--;
            end
            res_if.ready <= (hold_cycles == 0) && (stall_left == 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        logic [PAGE_W-1:0] pool [20];
        int                pool_size;
        int                counted;
        int                gap_max;
        int                pick;
        bit                drain;
        logic [PAGE_W-1:0] page;

        mismatches = 0;
        cycles     = 0;
        pool_size  = 8;
        gap_max    = 0;

        // directed: field extremes, ignored zero page, fills up to a full table,
        // hits, replacement with both victim extremes
        queue_ref(16'h0001, 3'd0, 0, 1'b0);
        queue_ref(16'hFFFF, 3'd7, 0, 1'b0);
        queue_ref(16'h0000, 3'd5, 0, 1'b0);
        queue_ref(16'h0001, 3'd3, 0, 1'b0);
        queue_ref(16'h5555, 3'd2, 1, 1'b0);
        queue_ref(16'hAAAA, 3'd5, 0, 1'b0);
        queue_ref(16'h8000, 3'd1, 0, 1'b0);
        queue_ref(16'h7FFF, 3'd6, 2, 1'b0);
        queue_ref(16'h00FF, 3'd4, 0, 1'b0);
        queue_ref(16'hFF00, 3'd0, 0, 1'b0);
        queue_ref(16'hFFFF, 3'd7, 0, 1'b0);
        queue_ref(16'h1234, 3'd0, 0, 1'b0);
        queue_ref(16'h4321, 3'd7, 0, 1'b0);
        queue_ref(16'h1234, 3'd2, 0, 1'b0);
        queue_ref(16'h0001, 3'd4, 0, 1'b0);
        queue_ref(16'h0000, 3'd7, 0, 1'b0);
        queue_ref(16'hFF00, 3'd1, 3, 1'b0);
        queue_ref(16'h0001, 3'd3, 0, 1'b0);

        // random: mostly a small working set so hits and replacements both happen
        counted = 0;
        while (counted < RANDOM_REFS) begin
            if (counted % 100 == 0) begin
                gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
            end
            if (counted % 150 == 0) begin
                pool_size = $urandom_range(4, 20);
                for (int k = 0; k < 20; k++) begin
                    pool[k] = 16'($urandom_range(1, 65535));
                end
            end
            pick  = $urandom_range(0, 99);
            drain = (counted == 0 || counted == 200 || counted == 700 || counted == 1200);
            if (pick < 4) begin
                // noise, ignored by the block and not counted
                queue_ref('0, 3'($urandom_range(0, 7)), $urandom_range(0, gap_max), 1'b0);
            end else begin
                if (pick < 80) begin
                    page = pool[$urandom_range(0, pool_size - 1)];
                end else if (pick < 94) begin
                    page = 16'($urandom_range(1, 65535));
                end else if (pick < 97) begin
                    page = 16'h0001;
                end else begin
                    page = 16'hFFFF;
                end
                queue_ref(page, 3'($urandom_range(0, 7)), $urandom_range(0, gap_max), drain);
                counted++;
            end
        end

        // sample on the falling edge, away from the clocked processes
        do begin
            @(negedge i_clk);
        end while (pending_refs.size() != 0 || loaded || outstanding != 0 ||
                   expected_outcomes.size() != 0);

        // let any stray result show up
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
src/rpr_pkg.sv
src/rpr_if.sv
src/rpr_cell.sv
src/random_page_replacement_unit.sv
src/rpr_checker.sv
tb/tb_random_page_replacement_unit.sv
